>>> rtl/core/checked_int24_alu_unit_defines.svh
// ---------------------------------------------------------------------------
// Checked int24 ALU assertion macros
// Shared property forms for the concurrent checks of the ALU unit.
// ---------------------------------------------------------------------------
`ifndef CHECKED_INT24_ALU_UNIT_DEFINES_SVH
`define CHECKED_INT24_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CI24_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CI24_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ci24_pkg.sv
// ---------------------------------------------------------------------------
// Checked int24 ALU package
// Widths, opcodes, status codes and word types shared by the ALU modules.
// ---------------------------------------------------------------------------
package ci24_pkg;

    localparam int DATA_WIDTH = 24;
    localparam int WIDE_WIDTH = 2 * DATA_WIDTH;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ZERO_DIV = 2'd2;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result_value;
        logic [1:0]                   status;
    } t_out_word;

    // Data that rides alongside the divider stages.
    typedef struct packed {
        logic [1:0]            op;
        logic                  zdiv;
        logic                  qneg;
        logic [WIDE_WIDTH-1:0] val;
    } t_side;

    // Restoring divider state: partial remainder, shifting dividend/quotient, divisor.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] dvs;
    } t_div;

endpackage

>>> rtl/core/ci24_div_pipe.sv
// ---------------------------------------------------------------------------
// Checked int24 ALU divider pipeline
// Unsigned restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module ci24_div_pipe
    import ci24_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  t_div                  i_div,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [DATA_WIDTH-1:0] o_quot
);

    logic  r_valid [DATA_WIDTH];
    t_side r_side  [DATA_WIDTH];
    t_div  r_div   [DATA_WIDTH];

    logic  w_valid [DATA_WIDTH+1];
    t_side w_side  [DATA_WIDTH+1];
    t_div  w_div   [DATA_WIDTH+1];

    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;
    assign w_div[0]   = i_div;

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
        logic [DATA_WIDTH:0] w_trial;
        logic                w_ge;
        t_div                n_div;

        assign w_valid[k+1] = r_valid[k];
        assign w_side[k+1]  = r_side[k];
        assign w_div[k+1]   = r_div[k];

        always_comb begin
            w_trial = {w_div[k].rem, w_div[k].nq[DATA_WIDTH-1]} - {1'b0, w_div[k].dvs};
            w_ge    = !w_trial[DATA_WIDTH];
            n_div.dvs = w_div[k].dvs;
            n_div.nq  = {w_div[k].nq[DATA_WIDTH-2:0], w_ge};
            if (w_ge) begin
                n_div.rem = w_trial[DATA_WIDTH-1:0];
            end else begin
                n_div.rem = {w_div[k].rem[DATA_WIDTH-2:0], w_div[k].nq[DATA_WIDTH-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side[k];
                r_div[k]  <= n_div;
            end
        end
    end

    assign o_valid = w_valid[DATA_WIDTH];
    assign o_side  = w_side[DATA_WIDTH];
    assign o_quot  = w_div[DATA_WIDTH].nq;

endmodule

>>> rtl/core/checked_int24_alu_unit.sv
// ---------------------------------------------------------------------------
// Checked int24 ALU unit
// Add, subtract, multiply or truncating divide of two signed 24-bit words,
// range-checked against the signed 24-bit range.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries opcode and both operands;
//   output channel o_out_valid / i_out_ready carries result and status.
//   Status is ok, overflow or zero divisor; on any error the result is zero.
//   From acceptance to o_out_valid a word passes one operand stage (add,
//   subtract, multiply, magnitudes), 24 divider stages retiring one
//   quotient bit each, and one check/output stage.
//   All opcodes take the same path, so results leave in input order.
//   Throughput is one word per cycle while the output is taken.
//   Reset clears every stage valid bit; the pipeline comes up empty.
//   When the receiver holds i_out_ready low with a word waiting, the whole
//   pipeline freezes and o_in_ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
`include "checked_int24_alu_unit_defines.svh"

module checked_int24_alu_unit
    import ci24_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic w_en;

    logic signed [DATA_WIDTH-1:0] w_a;
    logic signed [DATA_WIDTH-1:0] w_b;
    logic signed [WIDE_WIDTH-1:0] w_ax;
    logic signed [WIDE_WIDTH-1:0] w_bx;
    logic signed [WIDE_WIDTH-1:0] w_prod;

    t_side n_s0_side;
    t_div  n_s0_div;
    logic  r_s0_valid;
    t_side r_s0_side;
    t_div  r_s0_div;

    logic                  w_dp_valid;
    t_side                 w_dp_side;
    logic [DATA_WIDTH-1:0] w_dp_quot;

    logic [WIDE_WIDTH-1:0]   w_qx;
    logic [WIDE_WIDTH-1:0]   w_val;
    logic [DATA_WIDTH:0]     w_hi;
    logic                    w_fits;
    t_out_word               n_out_word;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // operand stage
    assign w_a    = i_in_word.operand_a;
    assign w_b    = i_in_word.operand_b;
    assign w_ax   = {{DATA_WIDTH{w_a[DATA_WIDTH-1]}}, w_a};
    assign w_bx   = {{DATA_WIDTH{w_b[DATA_WIDTH-1]}}, w_b};
    assign w_prod = w_a * w_b;

    always_comb begin
        n_s0_side.op   = i_in_word.opcode;
        n_s0_side.zdiv = (i_in_word.opcode == OP_DIV) && (w_b == '0);
        n_s0_side.qneg = w_a[DATA_WIDTH-1] ^ w_b[DATA_WIDTH-1];
        unique case (i_in_word.opcode)
            OP_ADD: n_s0_side.val = w_ax + w_bx;
            OP_SUB: n_s0_side.val = w_ax - w_bx;
            OP_MUL: n_s0_side.val = w_prod;
            OP_DIV: n_s0_side.val = '0;
        endcase
        n_s0_div.rem = '0;
        n_s0_div.nq  = w_a[DATA_WIDTH-1] ? DATA_WIDTH'(-w_a) : w_a;
        n_s0_div.dvs = w_b[DATA_WIDTH-1] ? DATA_WIDTH'(-w_b) : w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side <= n_s0_side;
            r_s0_div  <= n_s0_div;
        end
    end

    ci24_div_pipe u_div_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_side  (r_s0_side),
        .i_div   (r_s0_div),
        .o_valid (w_dp_valid),
        .o_side  (w_dp_side),
        .o_quot  (w_dp_quot)
    );

    // check stage
    always_comb begin
        w_qx = {{DATA_WIDTH{1'b0}}, w_dp_quot};
        if (w_dp_side.op == OP_DIV) begin
            w_val = w_dp_side.qneg ? -w_qx : w_qx;
        end else begin
            w_val = w_dp_side.val;
        end
        w_hi   = w_val[WIDE_WIDTH-1:DATA_WIDTH-1];
        w_fits = (&w_hi) || !(|w_hi);
        if (w_dp_side.zdiv) begin
            n_out_word.status       = ST_ZERO_DIV;
            n_out_word.result_value = '0;
        end else if (!w_fits) begin
            n_out_word.status       = ST_OVERFLOW;
            n_out_word.result_value = '0;
        end else begin
            n_out_word.status       = ST_OK;
            n_out_word.result_value = w_val[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `CI24_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_out_word.status != ST_OK), o_out_word.result_value == '0, "error word carries nonzero result")
    `CI24_ASSERT_NOW(a_zdiv_op, i_clk, i_rst_n, w_dp_valid && (n_out_word.status == ST_ZERO_DIV), w_dp_side.op == OP_DIV, "zero divisor status on non-divide")
    `CI24_ASSERT_NEXT(a_advance, i_clk, i_rst_n, w_en && w_dp_valid, o_out_valid, "finished word not registered at output")

endmodule
